// ===== rtl/core/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; every other file in rtl/core imports it.
package wsd_pkg;

  // One received byte with its end-of-buffer flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsd_in_t;

  // One result word.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode_seen;
    logic       end_mark;
  } wsd_out_t;

  // Up to two result words produced by one received byte, in order.
  typedef struct packed {
    logic [1:0] count;
    wsd_out_t   first;
    wsd_out_t   second;
  } wsd_res_t;

  // Parser phases
  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_CLOSE   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_CLOSE    = 2'd2;
  localparam logic [1:0] KIND_SHORT    = 2'd3;

  localparam logic [3:0] OP_CLOSE    = 4'h8;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== rtl/core/websocket_frame_deframer.sv =====
// Top level of the WebSocket frame deframer: input register, parser and
// result queue. Uses wsd_pkg, wsd_parse and wsd_outq.
//
// Takes one byte of a received buffer per clock and returns the unmasked
// payload bytes, then one status word (complete, close or short) on the
// buffer's last byte. A taken byte is held in the input register and parsed
// there once the queue has room; its words are then written into the queue.
// Throughput is one byte per clock as long as the result side keeps up; the
// last byte of a buffer that also carries payload makes two words, which leave
// the four-word result queue one per clock while not stalled, and the byte
// channel stalls whenever that queue cannot take two words.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     frame_valid,
  output logic     frame_stall,
  input  wsd_in_t  frame_word,
  output logic     item_valid,
  input  logic     item_stall,
  output wsd_out_t item_word
);

  logic     in_v;
  wsd_in_t  in_word;
  logic     room;
  logic     go;
  wsd_res_t res;

  assign go          = in_v && room;
  // hold the registered byte until the queue can take its words
  assign frame_stall = in_v && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!frame_stall) begin
      in_v <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && !frame_stall) begin
      in_word <= frame_word;
    end
  end

  wsd_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .word (in_word),
    .res  (res)
  );

  wsd_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .room       (room),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_word  (item_word)
  );

endmodule

// ===== rtl/core/wsd_parse.sv =====
// Frame header parser and payload unmasker: holds the per-frame state and
// turns one registered byte into up to two result words. Uses wsd_pkg.
module wsd_parse import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     go,
  input  wsd_in_t  word,
  output wsd_res_t res
);

  logic [2:0]  phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [63:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic        mask_on, mask_on_next;
  logic [63:0] payload_count, payload_count_next;
  logic [3:0]  opcode_hold, opcode_hold_next;
  logic        ext_long, ext_long_next;

  logic [7:0]  b;
  logic [6:0]  len7;
  logic [3:0]  hc_inc;
  logic [7:0]  key_byte;
  logic        have_data;
  wsd_out_t    data_item;
  wsd_out_t    status_item;
  logic [1:0]  status_kind;

  assign b      = word.rx_byte;
  assign len7   = b[6:0];
  assign hc_inc = header_count + 4'd1;

  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    frame_length_next  = frame_length;
    mask_key_next      = mask_key;
    mask_on_next       = mask_on;
    payload_count_next = payload_count;
    opcode_hold_next   = opcode_hold;
    ext_long_next      = ext_long;
    have_data          = 1'b0;
    status_kind        = KIND_SHORT;
    data_item          = '0;
    status_item        = '0;
    res                = '0;

    unique case (phase)
      PH_FIRST: begin
        opcode_hold_next = b[3:0];
        phase_next = (b[3:0] == OP_CLOSE) ? PH_CLOSE : PH_SECOND;
      end
      PH_SECOND: begin
        mask_on_next      = b[7];
        header_count_next = 4'd0;
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          ext_long_next     = (len7 == LEN_EXT64);
          frame_length_next = 64'd0;
          phase_next        = PH_EXTLEN;
        end else begin
          frame_length_next = {57'd0, len7};
          if (b[7]) begin
            phase_next = PH_MASK;
          end else begin
            payload_count_next = 64'd0;
            phase_next = (len7 == 7'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
      end
      PH_EXTLEN: begin
        frame_length_next = {frame_length[55:0], b};
        header_count_next = hc_inc;
        if (hc_inc == (ext_long ? EXT64_BYTES : EXT16_BYTES)) begin
          header_count_next = 4'd0;
          if (mask_on) begin
            phase_next = PH_MASK;
          end else begin
            payload_count_next = 64'd0;
            phase_next = (frame_length_next == 64'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
      end
      PH_MASK: begin
        mask_key_next     = {mask_key[23:0], b};
        header_count_next = hc_inc;
        if (hc_inc == KEY_BYTES) begin
          header_count_next  = 4'd0;
          payload_count_next = 64'd0;
          phase_next = (frame_length == 64'd0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        have_data          = 1'b1;
        payload_count_next = payload_count + 64'd1;
        // payload_count climbs from zero by one, so equality ends the frame
        if (payload_count_next == frame_length) begin
          phase_next = PH_DONE;
        end
      end
      default: begin
        // frame done or close frame: drop the byte
      end
    endcase

    data_item.kind        = KIND_DATA;
    data_item.data        = mask_on ? (b ^ key_byte) : b;
    data_item.opcode_seen = opcode_hold_next;
    data_item.end_mark    = 1'b0;

    // A one-byte buffer is short even when it opens a close frame.
    if (phase == PH_FIRST) begin
      status_kind = KIND_SHORT;
    end else if (phase_next == PH_DONE) begin
      status_kind = KIND_COMPLETE;
    end else if (phase_next == PH_CLOSE) begin
      status_kind = KIND_CLOSE;
    end else begin
      status_kind = KIND_SHORT;
    end
    status_item.kind        = status_kind;
    status_item.data        = 8'd0;
    status_item.opcode_seen = opcode_hold_next;
    status_item.end_mark    = 1'b1;

    if (word.buffer_end) begin
      phase_next         = PH_FIRST;
      header_count_next  = 4'd0;
      frame_length_next  = 64'd0;
      mask_key_next      = 32'd0;
      mask_on_next       = 1'b0;
      payload_count_next = 64'd0;
      ext_long_next      = 1'b0;
    end

    if (go) begin
      if (have_data) begin
        res.first  = data_item;
        res.second = status_item;
        res.count  = word.buffer_end ? 2'd2 : 2'd1;
      end else if (word.buffer_end) begin
        res.first = status_item;
        res.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      header_count  <= 4'd0;
      frame_length  <= 64'd0;
      mask_key      <= 32'd0;
      mask_on       <= 1'b0;
      payload_count <= 64'd0;
      opcode_hold   <= 4'd0;
      ext_long      <= 1'b0;
    end else if (go) begin
      phase         <= phase_next;
      header_count  <= header_count_next;
      frame_length  <= frame_length_next;
      mask_key      <= mask_key_next;
      mask_on       <= mask_on_next;
      payload_count <= payload_count_next;
      opcode_hold   <= opcode_hold_next;
      ext_long      <= ext_long_next;
    end
  end

  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    go && word.buffer_end |=> phase == PH_FIRST && header_count == 4'd0)
    else $error("parser did not restart after buffer end");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> frame_length != 64'd0 && payload_count < frame_length)
    else $error("payload phase with no payload left");

endmodule

// ===== rtl/core/wsd_outq.sv =====
// Four-word result queue between the parser and the result channel.
// Takes up to two words per cycle, gives one while the result channel does not stall. Uses wsd_pkg.
module wsd_outq import wsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  wsd_res_t res,
  output logic     room,
  output logic     item_valid,
  input  logic     item_stall,
  output wsd_out_t item_word
);

  wsd_out_t            q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp, rp;
  logic [QCNT_W-1:0]   cnt, cnt_next;
  logic                pop;
  logic [QCNT_W-1:0]   after_pop;

  assign item_valid = (cnt != '0);
  assign item_word  = q[rp];
  assign pop        = item_valid && !item_stall;
  assign after_pop  = cnt - {{(QCNT_W-1){1'b0}}, pop};
  // room for the largest burst one byte can make
  assign room       = (after_pop <= QCNT_W'(QUEUE_DEPTH - 2));
  assign cnt_next   = after_pop + {{(QCNT_W-2){1'b0}}, res.count};

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      q[wp] <= res.first;
    end
    if (res.count == 2'd2) begin
      q[wp + QPTR_W'(1)] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + res.count[QPTR_W-1:0];
      rp  <= rp + {{(QPTR_W-1){1'b0}}, pop};
      cnt <= cnt_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res.count != 2'd0 |-> cnt_next <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_pair_ends_buffer: assert property (@(posedge clk) disable iff (rst)
    res.count == 2'd2 |-> res.second.end_mark && res.first.kind == KIND_DATA)
    else $error("second word of a pair is not the buffer status");

endmodule

// ===== test/websocket_frame_deframer_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer: builds WebSocket buffers byte by byte,
// predicts payload and status words in-line, and checks them as they leave the block.
// Depends on wsd_pkg and the deframer RTL only.
module websocket_frame_deframer_test;
  import wsd_pkg::*;

  typedef enum logic [1:0] {FORM_7, FORM_16, FORM_64} len_form_t;

  typedef struct packed {
    wsd_in_t word;
    logic    drain;
  } rx_item_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     frame_valid = 1'b0;
  logic     frame_stall;
  wsd_in_t  frame_word = '0;
  logic     item_valid;
  logic     item_stall = 1'b0;
  wsd_out_t item_word;

  rx_item_t rx_bytes_q[$];
  wsd_out_t results_due[$];
  rx_item_t next_item;

  // parser state mirrored from the block
  logic [2:0]  ph;
  logic [3:0]  hdr_cnt;
  logic [3:0]  ext_bytes;
  logic [3:0]  op_held;
  logic [63:0] frame_len;
  logic [63:0] pay_cnt;
  logic [31:0] mask_word;
  logic        masked_on;

  int errors = 0;
  int bytes_taken = 0;
  int results_seen = 0;
  int buffers_queued = 0;
  int payload_words = 0;
  int status_count[4] = '{0, 0, 0, 0};
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  int holds_done = 0;

  websocket_frame_deframer u_dut (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame_word (frame_word),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_word  (item_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string what);
    errors++;
    $display("tb: error at %0t: %s", $time, what);
  endtask

  function automatic void queue_result(input logic [1:0] kind, input logic [7:0] data,
                                       input logic endm);
    wsd_out_t w;
    w.kind        = kind;
    w.data        = data;
    w.opcode_seen = op_held;
    w.end_mark    = endm;
    results_due = {results_due, w};
  endfunction

  function automatic void clear_frame();
    ph        = PH_FIRST;
    hdr_cnt   = '0;
    ext_bytes = '0;
    frame_len = '0;
    pay_cnt   = '0;
    mask_word = '0;
    masked_on = 1'b0;
  endfunction

  function automatic void begin_payload();
    pay_cnt = '0;
    ph = (frame_len == 0) ? PH_DONE : PH_PAYLOAD;
  endfunction

  function automatic void lengths_done();
    hdr_cnt = '0;
    if (masked_on) ph = PH_MASK;
    else begin_payload();
  endfunction

  // Advance the mirrored parser by one accepted byte and queue the words it causes.
  function automatic void parse_byte(input wsd_in_t w);
    logic [7:0] b;
    logic [6:0] len7;
    logic [7:0] key_byte;
    logic       one_byte;
    logic [1:0] status;
    b = w.rx_byte;
    one_byte = (ph == PH_FIRST);
    case (ph)
      PH_FIRST: begin
        op_held = b[3:0];
        ph = (b[3:0] == OP_CLOSE) ? PH_CLOSE : PH_SECOND;
      end
      PH_SECOND: begin
        masked_on = b[7];
        len7 = b[6:0];
        hdr_cnt = '0;
        if (len7 == LEN_EXT16) begin
          ext_bytes = EXT16_BYTES;
          frame_len = '0;
          ph = PH_EXTLEN;
        end else if (len7 == LEN_EXT64) begin
          ext_bytes = EXT64_BYTES;
          frame_len = '0;
          ph = PH_EXTLEN;
        end else begin
          frame_len = {57'd0, len7};
          lengths_done();
        end
      end
      PH_EXTLEN: begin
        frame_len = {frame_len[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= ext_bytes) lengths_done();
      end
      PH_MASK: begin
        mask_word = {mask_word[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= KEY_BYTES) begin
          hdr_cnt = '0;
          begin_payload();
        end
      end
      PH_PAYLOAD: begin
        // key bytes rotate most significant first
        key_byte = mask_word[8 * (3 - pay_cnt[1:0]) +: 8];
        queue_result(KIND_DATA, masked_on ? (b ^ key_byte) : b, 1'b0);
        payload_words++;
        pay_cnt = pay_cnt + 64'd1;
        if (pay_cnt >= frame_len) ph = PH_DONE;
      end
      default: ; // frame done or close: drop the byte
    endcase
    if (w.buffer_end) begin
      if (one_byte) status = KIND_SHORT;
      else if (ph == PH_DONE) status = KIND_COMPLETE;
      else if (ph == PH_CLOSE) status = KIND_CLOSE;
      else status = KIND_SHORT;
      queue_result(status, 8'h00, 1'b1);
      status_count[status]++;
      clear_frame();
    end
  endfunction

  // cut: -1 whole frame plus extra trailing bytes, -2 truncated at a random point,
  // otherwise the exact number of bytes in the buffer.
  task automatic add_buffer(input logic [3:0] op, input logic masked, input len_form_t form,
                            input logic [63:0] plen, input int cut, input int extra,
                            input logic drain);
    logic [7:0]  hdr [0:13];
    logic [31:0] key;
    logic [7:0]  r;
    rx_item_t    it;
    int          hlen;
    int          n;
    int          i;
    r = 8'($urandom);
    key = $urandom;
    hdr[0] = {r[7:4], op};
    case (form)
      FORM_7: begin
        hdr[1] = {masked, plen[6:0]};
        hlen = 2;
      end
      FORM_16: begin
        hdr[1] = {masked, LEN_EXT16};
        hdr[2] = plen[15:8];
        hdr[3] = plen[7:0];
        hlen = 4;
      end
      default: begin
        hdr[1] = {masked, LEN_EXT64};
        for (i = 0; i < 8; i++) hdr[2 + i] = plen[63 - 8 * i -: 8];
        hlen = 10;
      end
    endcase
    if (masked) begin
      for (i = 0; i < 4; i++) hdr[hlen + i] = key[31 - 8 * i -: 8];
      hlen += 4;
    end
    if (cut == -1) n = hlen + int'(plen) + extra;
    else if (cut == -2) n = $urandom_range(1, hlen + int'(plen) - 1);
    else n = cut;
    if (n < 1) n = 1;
    for (i = 0; i < n; i++) begin
      r = 8'($urandom);
      it.word.rx_byte = (i < hlen) ? hdr[i] : r;
      it.word.buffer_end = (i == n - 1);
      it.drain = drain && (i == 0);
      rx_bytes_q = {rx_bytes_q, it};
    end
    buffers_queued++;
  endtask

  // byte driver: feeds the block from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      send_gap = 0;
      op_held = '0;
      clear_frame();
    end else begin
      if (frame_valid && !frame_stall) begin
        parse_byte(frame_word);
        bytes_taken++;
        send_gap = (bytes_taken[6] || hold_left != 0) ? 0 : $urandom_range(0, 14);
      end
      if (frame_valid && frame_stall) begin
        // hold the stalled word
      end else if (send_gap != 0) begin
        send_gap--;
        frame_valid <= 1'b0;
      end else if (rx_bytes_q.size() != 0 &&
                   !(rx_bytes_q[0].drain && results_due.size() != 0)) begin
        next_item = rx_bytes_q.pop_front();
        frame_word <= next_item.word;
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-offs so the result queue fills and the byte side stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && bytes_taken >= 350 + 450 * holds_done) begin
      hold_left <= 150;
      holds_done <= holds_done + 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    wsd_out_t want;
    if (rst) begin
      item_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (item_valid && !item_stall) begin
        results_seen++;
        if (results_due.size() == 0) begin
          flag_error($sformatf("unexpected word %h", item_word));
        end else begin
          want = results_due.pop_front();
          if (item_word.kind != want.kind)
            flag_error($sformatf("kind %0d, want %0d", item_word.kind, want.kind));
          if (item_word.data != want.data)
            flag_error($sformatf("data %h, want %h", item_word.data, want.data));
          if (item_word.opcode_seen != want.opcode_seen)
            flag_error($sformatf("opcode %h, want %h", item_word.opcode_seen,
                                 want.opcode_seen));
          if (item_word.end_mark != want.end_mark)
            flag_error($sformatf("end_mark %b, want %b", item_word.end_mark,
                                 want.end_mark));
        end
        recv_gap = results_seen[5] ? 0 : $urandom_range(0, 14);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        item_stall <= 1'b1;
      end else begin
        item_stall <= (hold_left != 0);
      end
    end
  end

  initial begin
    logic [7:0]  r;
    logic [3:0]  op;
    logic        masked;
    logic [63:0] plen;
    len_form_t   form;
    int          sel;
    int          cut;
    int          extra;
    int          n;
    int          i;
    rx_item_t    it;

    // one-byte buffers, plain and close
    add_buffer(4'h1, 1'b0, FORM_7, 64'd0, 1, 0, 1'b0);
    add_buffer(OP_CLOSE, 1'b0, FORM_7, 64'd0, 1, 0, 1'b0);
    // close frame with a second byte
    add_buffer(OP_CLOSE, 1'b1, FORM_7, 64'd5, 2, 0, 1'b0);
    // empty payload, masked payload, header cut inside the extended length
    add_buffer(4'h2, 1'b0, FORM_7, 64'd0, -1, 0, 1'b0);
    add_buffer(4'h1, 1'b1, FORM_7, 64'd2, -1, 0, 1'b0);
    add_buffer(4'h0, 1'b1, FORM_16, 64'd300, 3, 0, 1'b0);
    // trailing byte after the frame, non-minimal 16-bit length after a drain
    add_buffer(4'hF, 1'b0, FORM_7, 64'd1, -1, 1, 1'b0);
    add_buffer(4'hA, 1'b0, FORM_16, 64'd1, -1, 0, 1'b1);

    while (rx_bytes_q.size() < 1100) begin
      sel = $urandom_range(0, 99);
      r = 8'($urandom);
      op = (sel < 8) ? OP_CLOSE : r[3:0];
      masked = r[7];
      plen = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 125)) :
                                           64'($urandom_range(0, 10));
      form = FORM_7;
      cut = ($urandom_range(0, 7) == 0) ? -2 : -1;
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (sel >= 60 && sel < 74) begin
        form = FORM_16;
      end else if (sel >= 74 && sel < 84) begin
        form = FORM_64;
      end else if (sel >= 84 && sel < 87) begin
        // large 16-bit length, buffer ends early
        form = FORM_16;
        plen = 64'($urandom_range(0, 65535));
        cut = (masked ? 8 : 4) + $urandom_range(0, 6);
      end else if (sel >= 87 && sel < 91) begin
        // huge 64-bit length, top bit random, always short
        form = FORM_64;
        plen = {$urandom, $urandom};
        cut = (masked ? 14 : 10) + $urandom_range(0, 6);
      end
      if (sel >= 91) begin
        // noise: random bytes as a buffer of their own
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          it.word.rx_byte = 8'($urandom);
          it.word.buffer_end = (i == n - 1);
          it.drain = 1'b0;
          rx_bytes_q = {rx_bytes_q, it};
        end
        buffers_queued++;
      end else begin
        if (cut == -2 && plen < 2) cut = -1;
        add_buffer(op, masked, form, plen, cut, extra, $urandom_range(0, 39) == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (rx_bytes_q.size() != 0 || frame_valid || results_due.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d bytes in %0d buffers, %0d words checked (%0d payload)",
             bytes_taken, buffers_queued, results_seen, payload_words);
    $display("tb: status complete %0d, close %0d, short %0d; %0d long receiver holds",
             status_count[KIND_COMPLETE], status_count[KIND_CLOSE],
             status_count[KIND_SHORT], holds_done);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
